// ----- rtl/tma_pkg.sv -----
// shared constants for the trimmed mean adc voltage block
// no dependencies; used by tma_accum, tma_scale and trimmed_mean_adc_voltage
`default_nettype none

package tma_pkg;

    // default sample width
    localparam int SAMPLE_BITS_DEF = 12;

    // group of samples and trimming
    localparam int GROUP_SIZE = 10;
    localparam int CNT_W      = $clog2(GROUP_SIZE);
    localparam int TRIM_SHIFT = 3;   // divide by 8

    // millivolt conversion: mean * VREF_MV * ratio / 2**FULL_SCALE_LOG2
    localparam int VREF_MV         = 2500;
    localparam int BATTERY_RATIO   = 3;
    localparam int FULL_SCALE_LOG2 = 12;
    localparam int SCALE_W         = 13;
    localparam int SCALE_PLAIN     = VREF_MV;
    localparam int SCALE_BATTERY   = VREF_MV * BATTERY_RATIO;

    // result field widths
    localparam int MV_W   = 13;
    localparam int MEAN_W = 12;

endpackage

`default_nettype wire

// ----- rtl/tma_accum.sv -----
// running sum, minimum and maximum over a group of samples
// uses tma_pkg; hands the finished group on to tma_scale
`default_nettype none

module tma_accum #(
    parameter int SAMPLE_BITS = tma_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // sample channel
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [SAMPLE_BITS-1:0]   i_sample,
    input  wire logic                     i_battery,
    // finished group
    output logic                          o_grp_valid,
    input  wire logic                     i_grp_stall,
    output logic [SAMPLE_BITS+3:0]        o_grp_sum,
    output logic [SAMPLE_BITS-1:0]        o_grp_min,
    output logic [SAMPLE_BITS-1:0]        o_grp_max,
    output logic                          o_grp_battery
);

    localparam int SUM_W = SAMPLE_BITS + 4;
    localparam logic [tma_pkg::CNT_W-1:0] LAST_CNT = tma_pkg::CNT_W'(tma_pkg::GROUP_SIZE - 1);

    logic [tma_pkg::CNT_W-1:0] r_count, n_count;
    logic [SUM_W-1:0]          r_sum, n_sum;
    logic [SAMPLE_BITS-1:0]    r_min, n_min;
    logic [SAMPLE_BITS-1:0]    r_max, n_max;

    logic                      r_grp_valid;
    logic [SUM_W-1:0]          r_grp_sum;
    logic [SAMPLE_BITS-1:0]    r_grp_min;
    logic [SAMPLE_BITS-1:0]    r_grp_max;
    logic                      r_grp_battery;

    logic w_accept;
    logic w_last;
    logic w_grp_free;

    assign w_grp_free = !r_grp_valid || !i_grp_stall;
    assign o_stall    = !w_grp_free;
    assign w_accept   = i_valid && w_grp_free;
    assign w_last     = (r_count == LAST_CNT);

    always_comb begin
        n_sum   = r_sum + SUM_W'(i_sample);
        n_min   = (i_sample < r_min) ? i_sample : r_min;
        n_max   = (i_sample > r_max) ? i_sample : r_max;
        n_count = r_count + 1'b1;
    end

    // group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_min   <= '1;
            r_max   <= '0;
        end else if (w_accept) begin
            if (w_last) begin
                r_count <= '0;
                r_sum   <= '0;
                r_min   <= '1;
                r_max   <= '0;
            end else begin
                r_count <= n_count;
                r_sum   <= n_sum;
                r_min   <= n_min;
                r_max   <= n_max;
            end
        end
    end

    // finished group hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_valid <= 1'b0;
        end else if (w_grp_free) begin
            r_grp_valid <= w_accept && w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_last) begin
            r_grp_sum     <= n_sum;
            r_grp_min     <= n_min;
            r_grp_max     <= n_max;
            r_grp_battery <= i_battery;
        end
    end

    assign o_grp_valid   = r_grp_valid;
    assign o_grp_sum     = r_grp_sum;
    assign o_grp_min     = r_grp_min;
    assign o_grp_max     = r_grp_max;
    assign o_grp_battery = r_grp_battery;

endmodule

`default_nettype wire

// ----- rtl/tma_scale.sv -----
// trimmed mean and millivolt conversion of one finished group
// uses tma_pkg; fed by tma_accum, drives the result channel
`default_nettype none

module tma_scale #(
    parameter int SAMPLE_BITS = tma_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // finished group
    input  wire logic                         i_grp_valid,
    output logic                              o_grp_stall,
    input  wire logic [SAMPLE_BITS+3:0]       i_grp_sum,
    input  wire logic [SAMPLE_BITS-1:0]       i_grp_min,
    input  wire logic [SAMPLE_BITS-1:0]       i_grp_max,
    input  wire logic                         i_grp_battery,
    // result channel
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [tma_pkg::MV_W-1:0]          o_millivolts,
    output logic [tma_pkg::MEAN_W-1:0]        o_trimmed_mean
);

    localparam int SUM_W  = SAMPLE_BITS + 4;
    localparam int PROD_W = SAMPLE_BITS + tma_pkg::SCALE_W;
    localparam int WIDE_W = SAMPLE_BITS + tma_pkg::MEAN_W;

    // mean stage
    logic                      r_m_valid;
    logic [SAMPLE_BITS-1:0]    r_m_mean;
    logic                      r_m_battery;
    // result stage
    logic                      r_o_valid;
    logic [tma_pkg::MV_W-1:0]  r_o_mv;
    logic [tma_pkg::MEAN_W-1:0] r_o_mean;

    logic                      w_out_free;
    logic                      w_m_free;
    logic [SUM_W-1:0]          w_diff;
    logic [SUM_W-1:0]          w_diff_sh;
    logic [tma_pkg::SCALE_W-1:0] w_scale;
    logic [PROD_W-1:0]         w_prod;
    logic [PROD_W-1:0]         w_prod_sh;
    logic [WIDE_W-1:0]         w_mean_wide;

    function automatic logic [tma_pkg::SCALE_W-1:0] battery_scale(input logic battery);
        logic [tma_pkg::SCALE_W-1:0] sel;
        sel = battery ? tma_pkg::SCALE_W'(tma_pkg::SCALE_BATTERY)
                      : tma_pkg::SCALE_W'(tma_pkg::SCALE_PLAIN);
        return sel;
    endfunction

    assign w_out_free  = !r_o_valid || !i_stall;
    assign w_m_free    = !r_m_valid || w_out_free;
    assign o_grp_stall = !w_m_free;

    // sum less one minimum and one maximum, then divide by 8
    assign w_diff    = i_grp_sum - SUM_W'(i_grp_min) - SUM_W'(i_grp_max);
    assign w_diff_sh = w_diff >> tma_pkg::TRIM_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_m_free) begin
            r_m_valid <= i_grp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m_free && i_grp_valid) begin
            r_m_mean    <= w_diff_sh[SAMPLE_BITS-1:0];
            r_m_battery <= i_grp_battery;
        end
    end

    // mean * 2500 * ratio / 4096
    assign w_scale     = battery_scale(r_m_battery);
    assign w_prod      = PROD_W'(r_m_mean) * PROD_W'(w_scale);
    assign w_prod_sh   = w_prod >> tma_pkg::FULL_SCALE_LOG2;
    assign w_mean_wide = {{tma_pkg::MEAN_W{1'b0}}, r_m_mean};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_out_free) begin
            r_o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_m_valid) begin
            r_o_mv   <= w_prod_sh[tma_pkg::MV_W-1:0];
            r_o_mean <= w_mean_wide[tma_pkg::MEAN_W-1:0];
        end
    end

    assign o_valid        = r_o_valid;
    assign o_millivolts   = r_o_mv;
    assign o_trimmed_mean = r_o_mean;

endmodule

`default_nettype wire

// ----- rtl/trimmed_mean_adc_voltage.sv -----
// top level: olympic trimmed mean of ten adc samples, in millivolts
// uses tma_pkg, tma_accum and tma_scale
// throughput: one sample per cycle while o_stall is low; one result per ten samples
// the result for a group is registered in the group hand-off, mean and result stages in turn
// the register stages (group hand-off, mean, result) each hold while stalled
// reset: synchronous, active low; clears the group, sets battery_channel to 1
`default_nettype none

module trimmed_mean_adc_voltage #(
    parameter int SAMPLE_BITS = tma_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration: battery_channel
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_wdata,
    // sample items
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [SAMPLE_BITS-1:0]        i_sample,
    // result items
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [tma_pkg::MV_W-1:0]           o_millivolts,
    output logic [tma_pkg::MEAN_W-1:0]         o_trimmed_mean
);

    // battery channel select, 1 means input behind a divide-by-three
    logic r_battery;

    // finished group between the accumulator and the scaler
    logic                   w_grp_valid;
    logic                   w_grp_stall;
    logic [SAMPLE_BITS+3:0] w_grp_sum;
    logic [SAMPLE_BITS-1:0] w_grp_min;
    logic [SAMPLE_BITS-1:0] w_grp_max;
    logic                   w_grp_battery;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_battery <= 1'b1;
        end else if (i_cfg_we) begin
            r_battery <= i_cfg_wdata;
        end
    end

    // sum, min and max per group; snapshot on the tenth item
    tma_accum #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .i_battery     (r_battery),
        .o_grp_valid   (w_grp_valid),
        .i_grp_stall   (w_grp_stall),
        .o_grp_sum     (w_grp_sum),
        .o_grp_min     (w_grp_min),
        .o_grp_max     (w_grp_max),
        .o_grp_battery (w_grp_battery)
    );

    // trim, divide by 8, then scale to millivolts
    tma_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_grp_valid    (w_grp_valid),
        .o_grp_stall    (w_grp_stall),
        .i_grp_sum      (w_grp_sum),
        .i_grp_min      (w_grp_min),
        .i_grp_max      (w_grp_max),
        .i_grp_battery  (w_grp_battery),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_millivolts   (o_millivolts),
        .o_trimmed_mean (o_trimmed_mean)
    );

endmodule

`default_nettype wire

// ----- bench/tb_trimmed_mean_adc_voltage.sv -----
// testbench for trimmed_mean_adc_voltage: feeds groups of adc samples and checks
// each trimmed mean and its millivolt value against a predictor kept in this file
// depends on tma_pkg and the trimmed_mean_adc_voltage rtl
`timescale 1ns / 1ps

module tb_trimmed_mean_adc_voltage;

    // group length and conversion constants, kept local to the predictor
    localparam int GROUP_LEN     = 10;
    localparam int MEAN_SHIFT    = 3;
    localparam int VREF_MV       = 2500;
    localparam int FULL_SCALE    = 4096;
    localparam int BATTERY_RATIO = 3;

    // mix of random and quiet cycles on both channels
    localparam int IDLE_PCT      = 7;
    // long receiver hold-off, in cycles
    localparam int LONG_HOLD     = 80;
    // cycles to let the pipeline settle after the last result
    localparam int SETTLE_CYCLES = 6;
    // cycles with nothing accepted before the run is called hung
    localparam int WATCHDOG_MAX  = 1000;

    typedef struct packed {
        logic [tma_pkg::MV_W-1:0]   millivolts;
        logic [tma_pkg::MEAN_W-1:0] trimmed_mean;
    } t_voltage_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic [11:0] i_sample    = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic [tma_pkg::MV_W-1:0]   o_millivolts;
    logic [tma_pkg::MEAN_W-1:0] o_trimmed_mean;

    // samples waiting for the driver, and trimmed means waiting for the dut
    logic [11:0]     pending_samples[$];
    t_voltage_result expected_results[$];

    // predictor copy of the group state and the channel register
    logic [3:0]  group_count = '0;
    logic [15:0] group_sum   = '0;
    logic [11:0] group_min   = '1;
    logic [11:0] group_max   = '0;
    logic        battery_sel = 1'b1;

    int mismatches     = 0;
    int samples_taken  = 0;
    int means_checked  = 0;
    int idle_cycles    = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    bit quiet          = 1'b0;
    int battery_writes = 0;

    // random fill state: one flavor of samples per group of ten
    int fill_pos  = 0;
    int fill_mode = 0;
    int fill_base = 0;

    trimmed_mean_adc_voltage dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_millivolts   (o_millivolts),
        .o_trimmed_mean (o_trimmed_mean)
    );

    always #5 i_clk = ~i_clk;

    task automatic log_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // fold one accepted sample into the group; on the tenth, queue the trimmed mean
    task automatic take_sample(input logic [11:0] s);
        int unsigned     mean;
        int unsigned     mv;
        t_voltage_result r;
        group_sum = group_sum + 16'(s);
        if (s < group_min) begin
            group_min = s;
        end
        if (s > group_max) begin
            group_max = s;
        end
        group_count = group_count + 4'd1;
        if (group_count == GROUP_LEN) begin
            // only one copy of min and one of max come out, duplicates stay in
            mean = (32'(group_sum) - 32'(group_min) - 32'(group_max)) >> MEAN_SHIFT;
            // ratio is whatever the register holds when the tenth sample lands
            mv = (mean * VREF_MV * (battery_sel ? BATTERY_RATIO : 1)) / FULL_SCALE;
            r.millivolts   = mv[tma_pkg::MV_W-1:0];
            r.trimmed_mean = mean[tma_pkg::MEAN_W-1:0];
            expected_results.push_back(r);
            group_count = '0;
            group_sum   = '0;
            group_min   = '1;
            group_max   = '0;
        end
    endtask

    // driver: holds the item while stalled, idles now and then
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                take_sample(i_sample);
                samples_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_samples.size() != 0 &&
                        (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    i_valid  <= 1'b1;
                    i_sample <= pending_samples.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: drives the result stall and checks every accepted result
    always @(posedge i_clk) begin
        t_voltage_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    log_mismatch($sformatf("result with no group pending: mv %0d mean %0d",
                                           o_millivolts, o_trimmed_mean));
                end else begin
                    want = expected_results.pop_front();
                    means_checked++;
                    if (o_trimmed_mean !== want.trimmed_mean) begin
                        log_mismatch($sformatf("trimmed_mean got %0d expected %0d",
                                               o_trimmed_mean, want.trimmed_mean));
                    end
                    if (o_millivolts !== want.millivolts) begin
                        log_mismatch($sformatf("millivolts got %0d expected %0d",
                                               o_millivolts, want.millivolts));
                    end
                end
            end
            // a long hold-off when asked, otherwise sparse random stalls
            if (hold_left != 0) begin
                i_stall   <= 1'b1;
                hold_left = hold_left - 1;
            end else if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = LONG_HOLD - 1;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // watchdog: any cycle with a handshake on either side resets the count
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("timeout: nothing accepted for %0d cycles, %0d means outstanding",
                         idle_cycles, expected_results.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // wait for the sender queue and every expected result, then let the pipe settle
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (pending_samples.size() != 0 || i_valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write battery_channel, then update the predictor's copy of it
    task automatic set_battery(input bit v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        battery_sel = v;
        battery_writes++;
    endtask

    // random samples, with a new flavor picked at each group boundary
    task automatic push_random(input int n);
        int          roll;
        logic [11:0] s;
        repeat (n) begin
            if (fill_pos == 0) begin
                roll = $urandom_range(99);
                if (roll < 50) begin
                    fill_mode = 0;  // uniform
                end else if (roll < 65) begin
                    fill_mode = 1;  // tight cluster, many duplicates
                end else if (roll < 75) begin
                    fill_mode = 2;  // constant group
                end else if (roll < 90) begin
                    fill_mode = 3;  // extremes mixed in
                end else begin
                    fill_mode = 4;  // only two values
                end
                case ($urandom_range(3))
                    0: begin
                        fill_base = 0;
                    end
                    1: begin
                        fill_base = 4095;
                    end
                    default: begin
                        fill_base = $urandom_range(4095);
                    end
                endcase
            end
            case (fill_mode)
                1: begin
                    s = 12'(fill_base + $urandom_range(6) - 3);
                end
                2: begin
                    s = 12'(fill_base);
                end
                3: begin
                    case ($urandom_range(3))
                        0: s = 12'd0;
                        1: s = 12'd4095;
                        default: s = 12'($urandom_range(4095));
                    endcase
                end
                4: begin
                    s = $urandom_range(1) ? 12'(fill_base) : ~12'(fill_base);
                end
                default: begin
                    s = 12'($urandom_range(4095));
                end
            endcase
            pending_samples.push_back(s);
            fill_pos = (fill_pos + 1) % GROUP_LEN;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed group at reset ratio: duplicated min and max, rails,
        // alternating bit patterns and mid-scale neighbors
        pending_samples.push_back(12'd0);
        pending_samples.push_back(12'd0);
        pending_samples.push_back(12'd4095);
        pending_samples.push_back(12'd4095);
        pending_samples.push_back(12'hAAA);
        pending_samples.push_back(12'h555);
        pending_samples.push_back(12'd2048);
        pending_samples.push_back(12'd2047);
        pending_samples.push_back(12'd1);
        pending_samples.push_back(12'd4094);
        wait_idle();

        // full-scale group with the channel switched halfway through:
        // the new ratio has to apply to the group already in progress
        repeat (5) pending_samples.push_back(12'd4095);
        wait_idle();
        set_battery(1'b0);
        repeat (5) pending_samples.push_back(12'd4095);
        wait_idle();

        // random phases; phases do not end on group boundaries, so most
        // register writes also land mid-group
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 0) begin
                set_battery(1'b1);
            end else if (ph == 1) begin
                set_battery(1'b0);
            end else begin
                set_battery(1'($urandom_range(1)));
            end
            // one phase runs flat out with no idling on either side
            quiet = (ph == 2);
            // one phase holds the results off long enough to back up the input
            if (ph == 4) begin
                hold_requests++;
            end
            push_random($urandom_range(45, 70));
            // sender pauses here until every expected mean has come back
            wait_idle();
        end
        quiet = 1'b0;

        $display("covered %0d samples and %0d trimmed means over %0d channel writes,",
                 samples_taken, means_checked, battery_writes);
        $display("with both ratios, rail and duplicate groups, and stalls on both sides");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
